// File: hdl/csb_pkg.sv
package csb_pkg;

  // Detector numbering: 1..CENTRAL_COUNT central, then inner pool, outer pool, rpc.
  localparam int unsigned DETECTOR_COUNT = 7;
  localparam int unsigned CENTRAL_COUNT  = 4;
  localparam int unsigned DET_W          = 3;
  localparam int unsigned TOTAL_W        = 3;

  // Field and register widths.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NANO_W    = 30;
  localparam int unsigned COUNT_W   = 12;
  localparam int unsigned ENERGY_W  = 20;
  localparam int unsigned NS_W      = 62;
  localparam int unsigned DIFF_W    = NS_W + 1;
  localparam int unsigned GAP_W     = 48;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] RPC_PATTERN = 32'h1004_0000;
  localparam logic [NANO_W-1:0] NS_PER_SEC  = 30'd1_000_000_000;

  localparam logic signed [GAP_W-1:0] GAP_MAX = {1'b0, {(GAP_W-1){1'b1}}};
  localparam logic signed [GAP_W-1:0] GAP_MIN = {1'b1, {(GAP_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT_MASK  = 3'd0,
    REG_LATENCY    = 3'd1,
    REG_ENERGY_THR = 3'd2,
    REG_INNER_THR  = 3'd3,
    REG_OUTER_THR  = 3'd4,
    REG_RETRIG_WIN = 3'd5
  } csb_reg_e;

  // One input word as captured by the input register.
  typedef struct packed {
    logic                action;
    logic [DET_W-1:0]    detector;
    logic [WORD_W-1:0]   trigger_word;
    logic [WORD_W-1:0]   time_sec;
    logic [NANO_W-1:0]   time_nano;
    logic [COUNT_W-1:0]  channel_count;
    logic [ENERGY_W-1:0] energy;
  } csb_raw_t;

  // A qualified word, ready for the grouping stage.
  typedef struct packed {
    logic                      flush;
    logic                      keep;
    logic [DETECTOR_COUNT-1:0] det_bit;
    logic                      muon_hit;
    logic [NS_W-1:0]           time_ns;
    logic [WORD_W-1:0]         time_sec;
    logic [NANO_W-1:0]         time_nano;
  } csb_item_t;

endpackage

// File: hdl/csb_qualify.sv
module csb_qualify (
  input  csb_pkg::csb_raw_t                   raw_i,
  input  logic [csb_pkg::WORD_W-1:0]          mult_mask_i,
  input  logic [csb_pkg::ENERGY_W-1:0]        energy_thr_i,
  input  logic [csb_pkg::COUNT_W-1:0]         inner_thr_i,
  input  logic [csb_pkg::COUNT_W-1:0]         outer_thr_i,
  output csb_pkg::csb_item_t                  item_o
);

  logic [csb_pkg::DET_W:0]            det_ext;
  logic                               mask_ok;
  logic                               det_ok;
  logic [csb_pkg::NS_W-1:0]           sec_ns;
  logic                               hit;
  logic [csb_pkg::DETECTOR_COUNT-1:0] det_bit;

  assign det_ext = {1'b0, raw_i.detector};

  // A readout counts only with every multiplicity bit set and a known detector.
  assign mask_ok = (raw_i.trigger_word & mult_mask_i) == mult_mask_i;
  assign det_ok  = (raw_i.detector != '0) &&
                   (det_ext <= (csb_pkg::DET_W+1)'(csb_pkg::DETECTOR_COUNT));

  // Trigger time in nanoseconds; a constant multiply of 32 by 30 bits.
  assign sec_ns = csb_pkg::NS_W'(raw_i.time_sec) * csb_pkg::NS_W'(csb_pkg::NS_PER_SEC);

  // Muon criterion of this readout, chosen by detector class.
  always_comb begin
    hit = 1'b0;
    if (det_ext <= (csb_pkg::DET_W+1)'(csb_pkg::CENTRAL_COUNT)) begin
      hit = raw_i.energy > energy_thr_i;
    end else if (det_ext == (csb_pkg::DET_W+1)'(csb_pkg::CENTRAL_COUNT + 1)) begin
      hit = raw_i.channel_count > inner_thr_i;
    end else if (det_ext == (csb_pkg::DET_W+1)'(csb_pkg::CENTRAL_COUNT + 2)) begin
      hit = raw_i.channel_count > outer_thr_i;
    end else if (det_ext == (csb_pkg::DET_W+1)'(csb_pkg::CENTRAL_COUNT + 3)) begin
      hit = (raw_i.trigger_word & csb_pkg::RPC_PATTERN) == csb_pkg::RPC_PATTERN;
    end
  end

  // One-hot detector bit, bit d-1 for detector d.
  always_comb begin
    for (int k = 0; k < csb_pkg::DETECTOR_COUNT; k++) begin
      det_bit[k] = det_ext == (csb_pkg::DET_W+1)'(k + 1);
    end
  end

  assign item_o.flush     = raw_i.action;
  assign item_o.keep      = !raw_i.action && mask_ok && det_ok;
  assign item_o.det_bit   = det_bit;
  assign item_o.muon_hit  = hit;
  assign item_o.time_ns   = sec_ns + csb_pkg::NS_W'(raw_i.time_nano);
  assign item_o.time_sec  = raw_i.time_sec;
  assign item_o.time_nano = raw_i.time_nano;

endmodule

// File: hdl/csb_gap.sv
module csb_gap (
  input  logic [csb_pkg::NS_W-1:0]          now_ns_i,
  input  logic [csb_pkg::NS_W-1:0]          prev_ns_i,
  input  logic                              prev_valid_i,
  output logic signed [csb_pkg::DIFF_W-1:0] diff_o,
  output logic signed [csb_pkg::GAP_W-1:0]  gap_o
);

  logic fits;

  // Full signed difference; both times are below 2^62.
  assign diff_o = $signed({1'b0, now_ns_i}) - $signed({1'b0, prev_ns_i});

  // The value fits in the gap width when all bits above its sign agree.
  assign fits = (diff_o[csb_pkg::DIFF_W-1:csb_pkg::GAP_W-1] == '0) ||
                (diff_o[csb_pkg::DIFF_W-1:csb_pkg::GAP_W-1] == '1);

  // Saturate; report the maximum when there is no earlier reference.
  always_comb begin
    if (!prev_valid_i) begin
      gap_o = csb_pkg::GAP_MAX;
    end else if (fits) begin
      gap_o = diff_o[csb_pkg::GAP_W-1:0];
    end else if (diff_o[csb_pkg::DIFF_W-1]) begin
      gap_o = csb_pkg::GAP_MIN;
    end else begin
      gap_o = csb_pkg::GAP_MAX;
    end
  end

endmodule

// File: hdl/coincidence_subevent_builder_core.sv
// Channel  | Direction | Handshake          | Word
// input    | in        | in_valid/in_ready  | action, detector, trigger, time, channels, energy
// output   | out       | out_valid/out_ready| sub-event time, mask, total, flags, gaps
// config   | in        | cfg_we             | cfg_index selects the register, cfg_data
//
// One word is taken per cycle while no held result stalls a closing word. A closing word
// passes the input register and the time stage register; the grouping stage then moves
// the sub-event into the output register. Its update of the open sub-event sets the rate.
// Reset clears the open sub-event, the previous sub-event and muon references and
// all configuration registers; no clearing pass is needed.
// A held result stalls only a word that closes a sub-event; others pass through.
module coincidence_subevent_builder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [csb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csb_pkg::WORD_W-1:0]          cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [csb_pkg::DET_W-1:0]           detector_i,
  input  logic [csb_pkg::WORD_W-1:0]          trigger_word_i,
  input  logic [csb_pkg::WORD_W-1:0]          time_sec_i,
  input  logic [csb_pkg::NANO_W-1:0]          time_nano_i,
  input  logic [csb_pkg::COUNT_W-1:0]         channel_count_i,
  input  logic [csb_pkg::ENERGY_W-1:0]        energy_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [csb_pkg::WORD_W-1:0]          subevent_sec_o,
  output logic [csb_pkg::NANO_W-1:0]          subevent_nano_o,
  output logic [csb_pkg::DETECTOR_COUNT-1:0]  detector_mask_o,
  output logic [csb_pkg::TOTAL_W-1:0]         detector_total_o,
  output logic                                muon_flag_o,
  output logic                                retrigger_flag_o,
  output logic signed [csb_pkg::GAP_W-1:0]    gap_previous_subevent_o,
  output logic signed [csb_pkg::GAP_W-1:0]    gap_previous_muon_o
);

  // Configuration registers.
  logic [csb_pkg::WORD_W-1:0]   mult_mask_q;
  logic [csb_pkg::WORD_W-1:0]   latency_q;
  logic [csb_pkg::ENERGY_W-1:0] energy_thr_q;
  logic [csb_pkg::COUNT_W-1:0]  inner_thr_q;
  logic [csb_pkg::COUNT_W-1:0]  outer_thr_q;
  logic [csb_pkg::WORD_W-1:0]   retrig_win_q;

  // Pipeline registers.
  logic               a_valid_q;
  csb_pkg::csb_raw_t  a_raw_q;
  logic               b_valid_q;
  csb_pkg::csb_item_t b_item_q;
  csb_pkg::csb_item_t item_d;

  // Open sub-event and reference times.
  logic                              open_q;
  logic [csb_pkg::DETECTOR_COUNT-1:0] occ_q;
  logic [csb_pkg::TOTAL_W-1:0]       total_q;
  logic                              muon_q;
  logic [csb_pkg::WORD_W-1:0]        first_sec_q;
  logic [csb_pkg::NANO_W-1:0]        first_nano_q;
  logic [csb_pkg::NS_W-1:0]          first_ns_q;
  logic                              last_sub_valid_q;
  logic [csb_pkg::NS_W-1:0]          last_sub_ns_q;
  logic                              last_muon_valid_q;
  logic [csb_pkg::NS_W-1:0]          last_muon_ns_q;

  // Output register.
  logic                                out_valid_q;
  logic [csb_pkg::WORD_W-1:0]          out_sec_q;
  logic [csb_pkg::NANO_W-1:0]          out_nano_q;
  logic [csb_pkg::DETECTOR_COUNT-1:0]  out_mask_q;
  logic [csb_pkg::TOTAL_W-1:0]         out_total_q;
  logic                                out_muon_q;
  logic                                out_retrig_q;
  logic signed [csb_pkg::GAP_W-1:0]    out_gap_sub_q;
  logic signed [csb_pkg::GAP_W-1:0]    out_gap_muon_q;

  // Handshake and decision signals.
  logic out_free;
  logic b_closes;
  logic b_fire;
  logic b_free;
  logic a_move;
  logic a_free;
  logic late;
  logic dup;
  logic start_new;

  logic signed [csb_pkg::DIFF_W-1:0] since_first;
  logic signed [csb_pkg::DIFF_W-1:0] diff_sub;
  logic signed [csb_pkg::DIFF_W-1:0] diff_muon;
  logic signed [csb_pkg::GAP_W-1:0]  gap_sub;
  logic signed [csb_pkg::GAP_W-1:0]  gap_muon;
  logic                              retrig;
  logic                              muon_diff_neg;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_mask_q  <= '0;
      latency_q    <= '0;
      energy_thr_q <= '0;
      inner_thr_q  <= '0;
      outer_thr_q  <= '0;
      retrig_win_q <= '0;
    end else if (cfg_we_i) begin
      unique case (csb_pkg::csb_reg_e'(cfg_index_i))
        csb_pkg::REG_MULT_MASK:  mult_mask_q  <= cfg_data_i;
        csb_pkg::REG_LATENCY:    latency_q    <= cfg_data_i;
        csb_pkg::REG_ENERGY_THR: energy_thr_q <= cfg_data_i[csb_pkg::ENERGY_W-1:0];
        csb_pkg::REG_INNER_THR:  inner_thr_q  <= cfg_data_i[csb_pkg::COUNT_W-1:0];
        csb_pkg::REG_OUTER_THR:  outer_thr_q  <= cfg_data_i[csb_pkg::COUNT_W-1:0];
        csb_pkg::REG_RETRIG_WIN: retrig_win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Qualification and time conversion between input register and grouping stage.
  csb_qualify u_qualify (
    .raw_i        (a_raw_q),
    .mult_mask_i  (mult_mask_q),
    .energy_thr_i (energy_thr_q),
    .inner_thr_i  (inner_thr_q),
    .outer_thr_i  (outer_thr_q),
    .item_o       (item_d)
  );

  // Gaps of the open sub-event to the previous sub-event and previous muon.
  csb_gap u_gap_sub (
    .now_ns_i     (first_ns_q),
    .prev_ns_i    (last_sub_ns_q),
    .prev_valid_i (last_sub_valid_q),
    .diff_o       (diff_sub),
    .gap_o        (gap_sub)
  );

  csb_gap u_gap_muon (
    .now_ns_i     (first_ns_q),
    .prev_ns_i    (last_muon_ns_q),
    .prev_valid_i (last_muon_valid_q),
    .diff_o       (diff_muon),
    .gap_o        (gap_muon)
  );

  assign retrig = last_sub_valid_q &&
                  (diff_sub < $signed({{(csb_pkg::DIFF_W-csb_pkg::WORD_W){1'b0}}, retrig_win_q}));

  // Close decision for the word in the grouping stage.
  assign since_first = $signed({1'b0, b_item_q.time_ns}) - $signed({1'b0, first_ns_q});
  assign late = since_first >
                $signed({{(csb_pkg::DIFF_W-csb_pkg::WORD_W){1'b0}}, latency_q});
  assign dup  = (occ_q & b_item_q.det_bit) != '0;

  assign b_closes  = open_q && (b_item_q.flush || (b_item_q.keep && (late || dup)));
  assign start_new = b_item_q.keep && (!open_q || b_closes);

  // Stage flow; only a closing word waits for room in the output register.
  assign out_free   = !out_valid_q || out_ready_i;
  assign b_fire     = b_valid_q && (!b_closes || out_free);
  assign b_free     = !b_valid_q || b_fire;
  assign a_move     = a_valid_q && b_free;
  assign a_free     = !a_valid_q || a_move;
  assign in_ready_o = a_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_free) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_free) begin
      a_raw_q.action        <= action_i;
      a_raw_q.detector      <= detector_i;
      a_raw_q.trigger_word  <= trigger_word_i;
      a_raw_q.time_sec      <= time_sec_i;
      a_raw_q.time_nano     <= time_nano_i;
      a_raw_q.channel_count <= channel_count_i;
      a_raw_q.energy        <= energy_i;
    end
  end

  // Time stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_item_q <= item_d;
    end
  end

  // Sub-event state: close, then open or extend.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q            <= 1'b0;
      occ_q             <= '0;
      total_q           <= '0;
      muon_q            <= 1'b0;
      first_sec_q       <= '0;
      first_nano_q      <= '0;
      first_ns_q        <= '0;
      last_sub_valid_q  <= 1'b0;
      last_sub_ns_q     <= '0;
      last_muon_valid_q <= 1'b0;
      last_muon_ns_q    <= '0;
    end else if (b_fire) begin
      if (b_closes) begin
        last_sub_valid_q <= 1'b1;
        last_sub_ns_q    <= first_ns_q;
        if (muon_q) begin
          last_muon_valid_q <= 1'b1;
          last_muon_ns_q    <= first_ns_q;
        end
        open_q  <= 1'b0;
        occ_q   <= '0;
        total_q <= '0;
        muon_q  <= 1'b0;
      end
      if (start_new) begin
        open_q       <= 1'b1;
        first_sec_q  <= b_item_q.time_sec;
        first_nano_q <= b_item_q.time_nano;
        first_ns_q   <= b_item_q.time_ns;
        occ_q        <= b_item_q.det_bit;
        total_q      <= csb_pkg::TOTAL_W'(1);
        muon_q       <= b_item_q.muon_hit;
      end else if (b_item_q.keep) begin
        occ_q   <= occ_q | b_item_q.det_bit;
        total_q <= total_q + csb_pkg::TOTAL_W'(1);
        muon_q  <= muon_q | b_item_q.muon_hit;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b_fire && b_closes;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && b_fire && b_closes) begin
      out_sec_q      <= first_sec_q;
      out_nano_q     <= first_nano_q;
      out_mask_q     <= occ_q;
      out_total_q    <= total_q;
      out_muon_q     <= muon_q;
      out_retrig_q   <= retrig;
      out_gap_sub_q  <= gap_sub;
      out_gap_muon_q <= gap_muon;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign subevent_sec_o          = out_sec_q;
  assign subevent_nano_o         = out_nano_q;
  assign detector_mask_o         = out_mask_q;
  assign detector_total_o        = out_total_q;
  assign muon_flag_o             = out_muon_q;
  assign retrigger_flag_o        = out_retrig_q;
  assign gap_previous_subevent_o = out_gap_sub_q;
  assign gap_previous_muon_o     = out_gap_muon_q;

  // Sign of the unsaturated difference to the previous muon sub-event.
  assign muon_diff_neg = diff_muon[csb_pkg::DIFF_W-1];

  // An open sub-event always holds at least one detector.
  a_open_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (occ_q != '0))
    else $error("open flag and occupancy disagree");

  // Each grouped readout adds a distinct detector.
  a_total_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(detector_mask_o) == int'(detector_total_o)))
    else $error("detector total differs from mask population");

  // A muon reference never exists without a sub-event reference.
  a_muon_ref : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_muon_valid_q |-> last_sub_valid_q)
    else $error("muon reference without sub-event reference");

  // A closing word that fires lands in the output register.
  a_close_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_closes) |=> out_valid_q)
    else $error("closed sub-event lost");

  // Retrigger implies a gap below the window.
  a_retrig_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && retrigger_flag_o) |->
      (gap_previous_subevent_o <
       $signed({{(csb_pkg::GAP_W-csb_pkg::WORD_W){1'b0}}, retrig_win_q})))
    else $error("retrigger flagged with gap above window");

  // A negative muon gap never saturates high.
  a_muon_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_muon_valid_q && muon_diff_neg) |-> gap_muon[csb_pkg::GAP_W-1])
    else $error("negative muon gap lost its sign");

endmodule
